FILE: hw/rtl/gno_pkg.sv
// gno_pkg: shared constants, configuration register indexes and the
// permutation table of the 3d gradient noise octave generator.
// No dependencies; used by gno_cell and gradient_noise_3d_octaves.
package gno_pkg;

  // parameter defaults
  localparam int MAX_OCTAVES_DEF = 10;
  localparam int FRAC_BITS_DEF   = 16;

  // configuration port
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int OCT_W   = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERSISTENCE  = 1'b1;
  localparam logic [OCT_W-1:0] OCT_RESET  = 4'd1;
  localparam logic [CFG_W-1:0] PERS_RESET = 16'd16384;

  // amplitude of the first octave, unsigned q1.15
  localparam int AMP_ONE = 32768;
  // result width, unsigned q0.16
  localparam int OUT_W = 16;

  // fixed permutation table
  localparam logic [7:0] PERM_TAB [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

  // table lookup, index wraps at 256
  function automatic logic [7:0] perm(input logic [7:0] idx);
    return PERM_TAB[idx];
  endfunction

endpackage

FILE: hw/rtl/gno_cell.sv
// gno_cell: one noise octave as a 12 stage pipeline; hashes, fades,
// interpolates and adds the weighted octave to the running total.
// Depends on gno_pkg (permutation table, widths).
module gno_cell #(
  parameter int IDX       = 0,
  parameter int FRAC_BITS = gno_pkg::FRAC_BITS_DEF,
  parameter int AMP_W     = 25,
  parameter int SUM_W     = 26,
  parameter int TOT_W     = 51
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [FRAC_BITS+7:0]          x_i,
  input  logic [FRAC_BITS+7:0]          y_i,
  input  logic [FRAC_BITS+7:0]          z_i,
  input  logic [AMP_W-1:0]              amp_i,
  input  logic [SUM_W-1:0]              sum_i,
  input  logic signed [TOT_W-1:0]       tot_i,
  input  logic [gno_pkg::OCT_W-1:0]     n_oct_i,
  input  logic [gno_pkg::CFG_W-1:0]     pers_i,
  output logic                          valid_o,
  output logic [FRAC_BITS+7:0]          x_o,
  output logic [FRAC_BITS+7:0]          y_o,
  output logic [FRAC_BITS+7:0]          z_o,
  output logic [AMP_W-1:0]              amp_o,
  output logic [SUM_W-1:0]              sum_o,
  output logic signed [TOT_W-1:0]       tot_o
);
  import gno_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int W   = F + 8;
  localparam int VW  = F + 4;
  localparam int MW  = 2 * F + 6;
  localparam int PW  = 2 * VW + 1;
  localparam int WPW = VW + AMP_W + 1;
  localparam int NP  = 11;
  localparam int ONE = 1 << F;

  logic [W-1:0] crd_in [3];
  assign crd_in[0] = x_i;
  assign crd_in[1] = y_i;
  assign crd_in[2] = z_i;

  // pass line: item data riding along the stages
  logic [NP-1:0]          pv_q;
  logic [W-1:0]           pc_q [NP][3];
  logic [AMP_W-1:0]       pa_q [NP];
  logic [SUM_W-1:0]       ps_q [NP];
  logic signed [TOT_W-1:0] pt_q [NP];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q    <= '0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      pv_q    <= {pv_q[NP-2:0], valid_i};
      valid_o <= pv_q[NP-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        pc_q[0][k] <= crd_in[k];
      end
      pa_q[0] <= amp_i;
      ps_q[0] <= sum_i;
      pt_q[0] <= tot_i;
      for (int s = 1; s < NP; s++) begin
        for (int k = 0; k < 3; k++) begin
          pc_q[s][k] <= pc_q[s-1][k];
        end
        pa_q[s] <= pa_q[s-1];
        ps_q[s] <= ps_q[s-1];
        pt_q[s] <= pt_q[s-1];
      end
    end
  end

  // stage 1: first hash level, fade products
  logic [7:0]            a1_q, b1_q;
  logic signed [F+4:0]   lin1 [3];
  logic signed [MW-1:0]  m1_d [3], m1_q [3];
  logic [2*F-1:0]        m2_d [3], m2_q [3];
  logic [7:0]            xi1;

  assign xi1 = crd_in[0][F+7:F];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lin1[k] = $signed((F+5)'(crd_in[k][F-1:0]) * (F+5)'(6) - ((F+5)'(15) << F));
      m1_d[k] = $signed({1'b0, crd_in[k][F-1:0]}) * lin1[k];
      m2_d[k] = crd_in[k][F-1:0] * crd_in[k][F-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q <= perm(xi1);
      b1_q <= perm(8'(xi1 + 8'd1));
      m1_q <= m1_d;
      m2_q <= m2_d;
    end
  end

  // stage 2: second hash level, fade inner term and cube
  logic [7:0]            hb2_q [4];
  logic [7:0]            yi2;
  logic signed [F+4:0]   inner2_d [3], inner2_q [3];
  logic [2*F-1:0]        m3_d [3], m3_q [3];

  assign yi2 = pc_q[0][1][F+7:F];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      inner2_d[k] = (F+5)'((m1_q[k] >>> F) + MW'(10 << F));
      m3_d[k]     = m2_q[k][2*F-1:F] * pc_q[0][k][F-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hb2_q[0] <= perm(8'(a1_q + yi2));
      hb2_q[1] <= perm(8'(b1_q + yi2));
      hb2_q[2] <= perm(8'(a1_q + yi2 + 8'd1));
      hb2_q[3] <= perm(8'(b1_q + yi2 + 8'd1));
      inner2_q <= inner2_d;
      m3_q     <= m3_d;
    end
  end

  // stage 3: corner hashes, fade final product
  logic [3:0]            h3_d [8], h3_q [8];
  logic [7:0]            zi3;
  logic signed [MW-1:0]  m4_d [3], m4_q [3];

  assign zi3 = pc_q[1][2][F+7:F];

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      h3_d[k] = 4'(perm(8'(hb2_q[k & 3] + zi3 + ((k >= 4) ? 8'd1 : 8'd0))));
    end
    for (int k = 0; k < 3; k++) begin
      m4_d[k] = $signed({1'b0, m3_q[k][2*F-1:F]}) * inner2_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h3_q <= h3_d;
      m4_q <= m4_d;
    end
  end

  // stage 4: corner gradients, corner k = dz*4 + dy*2 + dx
  logic signed [VW-1:0] fr0 [3], fr1 [3];
  logic signed [VW-1:0] px [8], py [8], pz [8], gu [8], gv [8];
  logic signed [VW-1:0] g4_d [8], g4_q [8];
  logic signed [VW-1:0] f4_d [3], f4_q [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      fr0[a]  = $signed(VW'(pc_q[2][a][F-1:0]));
      fr1[a]  = fr0[a] - VW'(ONE);
      f4_d[a] = VW'(m4_q[a] >>> F);
    end
    for (int k = 0; k < 8; k++) begin
      px[k] = ((k & 1) != 0) ? fr1[0] : fr0[0];
      py[k] = ((k & 2) != 0) ? fr1[1] : fr0[1];
      pz[k] = ((k & 4) != 0) ? fr1[2] : fr0[2];
      // rule selects u and v, low two bits negate them
      gu[k] = h3_q[k][3] ? py[k] : px[k];
      if (h3_q[k][3:2] == 2'b00) begin
        gv[k] = py[k];
      end else if (h3_q[k][3:2] == 2'b11 && !h3_q[k][0]) begin
        gv[k] = px[k];
      end else begin
        gv[k] = pz[k];
      end
      g4_d[k] = (h3_q[k][0] ? -gu[k] : gu[k]) + (h3_q[k][1] ? -gv[k] : gv[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g4_q <= g4_d;
      f4_q <= f4_d;
    end
  end

  // stages 5 and 6: blend along x
  logic signed [VW:0]    d5 [4];
  logic signed [PW-1:0]  p5_d [4], p5_q [4];
  logic signed [VW-1:0]  a5_q [4], fv5_q, fw5_q;
  logic signed [VW-1:0]  l6_d [4], l6_q [4], fv6_q, fw6_q;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      d5[j]   = (VW+1)'(g4_q[2*j+1]) - (VW+1)'(g4_q[2*j]);
      p5_d[j] = f4_q[0] * d5[j];
      l6_d[j] = VW'(a5_q[j] + VW'(p5_q[j] >>> F));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p5_q  <= p5_d;
      for (int j = 0; j < 4; j++) begin
        a5_q[j] <= g4_q[2*j];
      end
      fv5_q <= f4_q[1];
      fw5_q <= f4_q[2];
      l6_q  <= l6_d;
      fv6_q <= fv5_q;
      fw6_q <= fw5_q;
    end
  end

  // stages 7 and 8: blend along y
  logic signed [VW:0]    d7 [2];
  logic signed [PW-1:0]  p7_d [2], p7_q [2];
  logic signed [VW-1:0]  a7_q [2], fw7_q;
  logic signed [VW-1:0]  l8_d [2], l8_q [2], fw8_q;

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      d7[j]   = (VW+1)'(l6_q[2*j+1]) - (VW+1)'(l6_q[2*j]);
      p7_d[j] = fv6_q * d7[j];
      l8_d[j] = VW'(a7_q[j] + VW'(p7_q[j] >>> F));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p7_q  <= p7_d;
      for (int j = 0; j < 2; j++) begin
        a7_q[j] <= l6_q[2*j];
      end
      fw7_q <= fw6_q;
      l8_q  <= l8_d;
      fw8_q <= fw7_q;
    end
  end

  // stages 9 and 10: blend along z, map to (r + 1) / 2
  logic signed [VW:0]    d9;
  logic signed [PW-1:0]  p9_d, p9_q;
  logic signed [VW-1:0]  a9_q;
  logic signed [VW+1:0]  r10;
  logic signed [VW-1:0]  ov10_q;

  always_comb begin
    d9   = (VW+1)'(l8_q[1]) - (VW+1)'(l8_q[0]);
    p9_d = fw8_q * d9;
    r10  = (VW+2)'(a9_q) + (VW+2)'(p9_q >>> F) + (VW+2)'(ONE);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p9_q   <= p9_d;
      a9_q   <= l8_q[0];
      ov10_q <= VW'(r10 >>> 1);
    end
  end

  // stage 11: weight by the octave amplitude
  logic signed [WPW-1:0] wp11_d, wp11_q;

  assign wp11_d = ov10_q * $signed({1'b0, pa_q[NP-2]});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wp11_q <= wp11_d;
    end
  end

  // stage 12: accumulate and hand on to the next octave
  logic                  act;
  logic [AMP_W+15:0]     ampp;

  assign act  = (5'(IDX) < {1'b0, n_oct_i});
  assign ampp = pa_q[NP-1] * pers_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tot_o <= pt_q[NP-1] + (act ? TOT_W'(wp11_q) : '0);
      sum_o <= ps_q[NP-1] + (act ? SUM_W'(pa_q[NP-1]) : '0);
      amp_o <= AMP_W'(ampp >> 15);
      x_o   <= {pc_q[NP-1][0][W-2:0], 1'b0};
      y_o   <= {pc_q[NP-1][1][W-2:0], 1'b0};
      z_o   <= {pc_q[NP-1][2][W-2:0], 1'b0};
    end
  end

endmodule

FILE: hw/rtl/gno_div.sv
// gno_div: pipelined restoring divider of the weighted total by the
// amplitude sum, one quotient bit per stage, with overflow and sign flags.
// No dependencies.
module gno_div #(
  parameter int TOT_W = 51,
  parameter int SUM_W = 26,
  parameter int QB    = 17
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [TOT_W-1:0] tot_i,
  input  logic [SUM_W-1:0]        sum_i,
  output logic                    valid_o,
  output logic [QB-1:0]           quo_o,
  output logic                    sat_o,
  output logic                    neg_o
);

  localparam int DW = (TOT_W - 1 > SUM_W + QB) ? TOT_W - 1 : SUM_W + QB;
  localparam int NS = QB + 1;

  logic [NS-1:0]    vld_q, sat_q, neg_q;
  logic [DW-1:0]    rem_d [QB], rem_q [QB];
  logic [SUM_W-1:0] den_q [QB];
  logic [QB-1:0]    quo_d [NS], quo_q [NS];
  logic [DW-1:0]    trial [NS];
  logic [NS-1:0]    ge;
  logic [DW-1:0]    num0;

  assign num0 = DW'(tot_i[TOT_W-2:0]);

  // stage 0 checks for overflow, stage s settles quotient bit QB - s
  always_comb begin
    trial[0] = DW'(sum_i) << QB;
    ge[0]    = (num0 >= trial[0]);
    rem_d[0] = num0;
    quo_d[0] = '0;
    for (int s = 1; s < NS; s++) begin
      trial[s] = DW'(den_q[s-1]) << (QB - s);
      ge[s]    = (rem_q[s-1] >= trial[s]);
      quo_d[s] = ge[s] ? (quo_q[s-1] | (QB'(1) << (QB - s))) : quo_q[s-1];
      if (s < QB) begin
        rem_d[s] = ge[s] ? (rem_q[s-1] - trial[s]) : rem_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q <= {sat_q[NS-2:0], ge[0]};
      neg_q <= {neg_q[NS-2:0], tot_i[TOT_W-1]};
      rem_q <= rem_d;
      quo_q <= quo_d;
      den_q[0] <= sum_i;
      for (int s = 1; s < QB; s++) begin
        den_q[s] <= den_q[s-1];
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign quo_o   = quo_q[NS-1];
  assign sat_o   = sat_q[NS-1];
  assign neg_o   = neg_q[NS-1];

endmodule

FILE: hw/rtl/gradient_noise_3d_octaves.sv
// gradient_noise_3d_octaves: fractal sum of 3d gradient noise octaves.
// One 12 stage cell per octave, a divider of FRAC_BITS + 2 stages, output reg.
// Throughput one point per cycle; the whole pipe holds while a valid output
// is stalled. Reset clears all valid bits; octave_count resets to 1,
// persistence to 16384.
// Depends on gno_pkg, gno_cell, gno_div.
module gradient_noise_3d_octaves #(
  parameter int MAX_OCTAVES = gno_pkg::MAX_OCTAVES_DEF,
  parameter int FRAC_BITS   = gno_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [FRAC_BITS+7:0]            x_coord_i,
  input  logic [FRAC_BITS+7:0]            y_coord_i,
  input  logic [FRAC_BITS+7:0]            z_coord_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [gno_pkg::OUT_W-1:0]       noise_value_o,
  input  logic                            cfg_we_i,
  input  logic [gno_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gno_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import gno_pkg::*;

  localparam int W     = FRAC_BITS + 8;
  localparam int AMP_W = 15 + MAX_OCTAVES;
  localparam int SUM_W = 16 + MAX_OCTAVES;
  localparam int TOT_W = FRAC_BITS + 4 + AMP_W + 1 + $clog2(MAX_OCTAVES + 1);
  localparam int QB    = FRAC_BITS + 1;

  // configuration registers
  logic [OCT_W-1:0] oct_q;
  logic [CFG_W-1:0] pers_q;
  logic [OCT_W-1:0] n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_q  <= OCT_RESET;
      pers_q <= PERS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OCTAVE_COUNT: oct_q  <= cfg_wdata_i[OCT_W-1:0];
        CFG_PERSISTENCE:  pers_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // zero octaves acts as one, too many is clipped
  always_comb begin
    if (oct_q == '0) begin
      n_eff = OCT_W'(1);
    end else if ({1'b0, oct_q} > 5'(MAX_OCTAVES)) begin
      n_eff = OCT_W'(MAX_OCTAVES);
    end else begin
      n_eff = oct_q;
    end
  end

  // global advance: the output register is free or its transfer completes
  logic en;
  logic out_valid_q;
  logic [OUT_W-1:0] noise_q;

  assign en          = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = out_valid_q;
  assign noise_value_o = noise_q;

  // chain of octave cells
  logic                    cv [MAX_OCTAVES+1];
  logic [W-1:0]            cx [MAX_OCTAVES+1];
  logic [W-1:0]            cy [MAX_OCTAVES+1];
  logic [W-1:0]            cz [MAX_OCTAVES+1];
  logic [AMP_W-1:0]        ca [MAX_OCTAVES+1];
  logic [SUM_W-1:0]        cs [MAX_OCTAVES+1];
  logic signed [TOT_W-1:0] ct [MAX_OCTAVES+1];

  assign cv[0] = in_valid_i;
  assign cx[0] = x_coord_i;
  assign cy[0] = y_coord_i;
  assign cz[0] = z_coord_i;
  assign ca[0] = AMP_W'(AMP_ONE);
  assign cs[0] = '0;
  assign ct[0] = '0;

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_cell
    gno_cell #(
      .IDX       (i),
      .FRAC_BITS (FRAC_BITS),
      .AMP_W     (AMP_W),
      .SUM_W     (SUM_W),
      .TOT_W     (TOT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cv[i]),
      .x_i     (cx[i]),
      .y_i     (cy[i]),
      .z_i     (cz[i]),
      .amp_i   (ca[i]),
      .sum_i   (cs[i]),
      .tot_i   (ct[i]),
      .n_oct_i (n_eff),
      .pers_i  (pers_q),
      .valid_o (cv[i+1]),
      .x_o     (cx[i+1]),
      .y_o     (cy[i+1]),
      .z_o     (cz[i+1]),
      .amp_o   (ca[i+1]),
      .sum_o   (cs[i+1]),
      .tot_o   (ct[i+1])
    );
  end

  // normalize by the amplitude sum
  logic          dv, dsat, dneg;
  logic [QB-1:0] dquo;

  gno_div #(
    .TOT_W (TOT_W),
    .SUM_W (SUM_W),
    .QB    (QB)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cv[MAX_OCTAVES]),
    .tot_i   (ct[MAX_OCTAVES]),
    .sum_i   (cs[MAX_OCTAVES]),
    .valid_o (dv),
    .quo_o   (dquo),
    .sat_o   (dsat),
    .neg_o   (dneg)
  );

  // rescale to q0.16 and saturate
  logic [QB+OUT_W-1:0] scaled;
  logic [OUT_W-1:0]    res;

  assign scaled = {dquo, {OUT_W{1'b0}}} >> FRAC_BITS;

  always_comb begin
    if (dneg) begin
      res = '0;
    end else if (dsat || scaled > (QB+OUT_W)'({OUT_W{1'b1}})) begin
      res = '1;
    end else begin
      res = scaled[OUT_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      noise_q <= res;
    end
  end

endmodule

FILE: tb/gradient_noise_3d_octaves_tb.sv
// gradient_noise_3d_octaves_tb: self-checking bench for the fractal 3d gradient noise block.
// Drives directed and random points (random ones under idle/stall mixes), checks against an
// in-bench fixed-point predictor. Depends on gno_pkg and gradient_noise_3d_octaves.
module gradient_noise_3d_octaves_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gno_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int MAXO = MAX_OCTAVES_DEF;
  localparam int CW = FB + 8;
  localparam longint ONE = 64'sd1 <<< FB;
  localparam int LATENCY = 12 * MAXO + FB + 3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [CW-1:0] x_coord_i = '0, y_coord_i = '0, z_coord_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [OUT_W-1:0] noise_value_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_OCTAVE_COUNT;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  gradient_noise_3d_octaves dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // bench copy of the configuration
  logic [OCT_W-1:0] octaves_cfg;
  logic [CFG_W-1:0] persist_cfg;

  logic [OUT_W-1:0] expected_noise[$];
  int mismatches = 0;
  int checked = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // floor product of two fixed-point values
  function automatic longint fmul(longint a, longint b);
    return (a * b) >>> FB;
  endfunction

  function automatic longint fade_w(longint t);
    longint inner, t3;
    inner = fmul(t, 6 * t - 15 * ONE) + 10 * ONE;
    t3 = fmul(fmul(t, t), t);
    return fmul(t3, inner);
  endfunction

  function automatic longint blend(longint a, longint b, longint w);
    return a + fmul(w, b - a);
  endfunction

  function automatic longint corner_dot(logic [7:0] hash, longint x, longint y, longint z);
    logic [3:0] h;
    longint u, v;
    h = hash[3:0];
    u = (h < 8) ? x : y;
    if (h < 4) v = y;
    else if (h == 12 || h == 14) v = x;
    else v = z;
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic [7:0] pt(int i);
    return PERM_TAB[i & 255];
  endfunction

  // one octave mapped to (r + 1) / 2
  function automatic longint octave_value(longint sx, longint sy, longint sz);
    int xi, yi, zi, a, b, aa, ab, ba, bb;
    longint xf, yf, zf, u, v, w, x1, x2, y1, y2, r;
    xi = (sx >>> FB) & 255; yi = (sy >>> FB) & 255; zi = (sz >>> FB) & 255;
    xf = sx & (ONE - 1); yf = sy & (ONE - 1); zf = sz & (ONE - 1);
    u = fade_w(xf); v = fade_w(yf); w = fade_w(zf);
    a = pt(xi); b = pt(xi + 1);
    aa = pt(a + yi); ab = pt(a + yi + 1); ba = pt(b + yi); bb = pt(b + yi + 1);
    x1 = blend(corner_dot(pt(aa + zi), xf, yf, zf), corner_dot(pt(ba + zi), xf - ONE, yf, zf), u);
    x2 = blend(corner_dot(pt(ab + zi), xf, yf - ONE, zf),
               corner_dot(pt(bb + zi), xf - ONE, yf - ONE, zf), u);
    y1 = blend(x1, x2, v);
    x1 = blend(corner_dot(pt(aa + zi + 1), xf, yf, zf - ONE),
               corner_dot(pt(ba + zi + 1), xf - ONE, yf, zf - ONE), u);
    x2 = blend(corner_dot(pt(ab + zi + 1), xf, yf - ONE, zf - ONE),
               corner_dot(pt(bb + zi + 1), xf - ONE, yf - ONE, zf - ONE), u);
    y2 = blend(x1, x2, v);
    r = blend(y1, y2, w) + ONE;
    return r >>> 1;
  endfunction

  function automatic logic [OUT_W-1:0] predict_noise(logic [CW-1:0] x, logic [CW-1:0] y,
                                                     logic [CW-1:0] z);
    int n;
    longint total, amp_sum, amp, q;
    n = octaves_cfg;
    if (n == 0) n = 1;
    if (n > MAXO) n = MAXO;
    total = 0; amp_sum = 0; amp = AMP_ONE;
    for (int i = 0; i < n; i++) begin
      total += octave_value(longint'(x) << i, longint'(y) << i, longint'(z) << i) * amp;
      amp_sum += amp;
      amp = (amp * longint'(persist_cfg)) >>> 15;
    end
    q = total / amp_sum;
    if (q < 0) q = 0;
    if (FB >= 16) q = q >>> (FB - 16);
    else q = q <<< (16 - FB);
    if (q > 65535) q = 65535;
    return q[OUT_W-1:0];
  endfunction

  // receiver stall pattern
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_noise.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result noise_value=%0d", noise_value_o);
      end else begin
        logic [OUT_W-1:0] exp_v;
        exp_v = expected_noise.pop_front();
        checked++;
        if (noise_value_o !== exp_v) begin
          mismatches++;
          if (mismatches <= 10)
            $display("noise_value mismatch: expected %0d got %0d", exp_v, noise_value_o);
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_OCTAVE_COUNT) octaves_cfg = val[OCT_W-1:0];
    else persist_cfg = val;
  endtask

  // send one point; prediction captured at the accepting edge
  task automatic send_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
                            int exp_known, logic [OUT_W-1:0] exp_v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_coord_i <= x; y_coord_i <= y; z_coord_i <= z;
    do @(posedge clk_i); while (in_stall_o);
    expected_noise.push_back(exp_known ? exp_v : predict_noise(x, y, z));
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_noise.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic random_run(int count);
    logic [CW-1:0] x, y, z;
    for (int i = 0; i < count; i++) begin
      x = $urandom(); y = $urandom(); z = $urandom();
      // some points on cell boundaries and fractions just below one
      if ($urandom_range(9) == 0) x[FB-1:0] = '0;
      if ($urandom_range(9) == 0) y[FB-1:0] = '1;
      send_point(x, y, z, 0, '0);
    end
  endtask

  typedef struct {
    logic [CW-1:0] x, y, z;
    int known;
    logic [OUT_W-1:0] val;
  } point_row_t;

  // directed points: lattice origin gives exactly one half
  point_row_t directed[] = '{
    '{24'h000000, 24'h000000, 24'h000000, 1, 16'h8000},
    '{24'h050000, 24'h7f0000, 24'hff0000, 1, 16'h8000},
    '{24'hffffff, 24'hffffff, 24'hffffff, 0, 16'h0},
    '{24'h000001, 24'h000001, 24'h000001, 0, 16'h0},
    '{24'h00ffff, 24'h00ffff, 24'h00ffff, 0, 16'h0},
    '{24'h008000, 24'h008000, 24'h008000, 0, 16'h0},
    '{24'h808080, 24'h404040, 24'h202020, 0, 16'h0},
    '{24'haaaaaa, 24'h555555, 24'hf0f0f0, 0, 16'h0},
    '{24'h123456, 24'hfedcba, 24'h0f0f0f, 0, 16'h0},
    '{24'hff8000, 24'h00ffff, 24'h7fffff, 0, 16'h0}
  };

  initial begin
    octaves_cfg = OCT_RESET;
    persist_cfg = PERS_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at reset settings, then with eight octaves
    foreach (directed[i])
      send_point(directed[i].x, directed[i].y, directed[i].z, directed[i].known, directed[i].val);
    drain();
    write_reg(CFG_OCTAVE_COUNT, 16'd8);
    foreach (directed[i]) send_point(directed[i].x, directed[i].y, directed[i].z, 0, '0);
    drain();

    // zero and oversized octave counts, persistence extremes
    write_reg(CFG_OCTAVE_COUNT, 16'd0);
    write_reg(CFG_PERSISTENCE, 16'd0);
    random_run(150);
    drain();
    write_reg(CFG_OCTAVE_COUNT, 16'd15);
    write_reg(CFG_PERSISTENCE, 16'd32768);
    random_run(250);
    drain();
    write_reg(CFG_PERSISTENCE, 16'hffff);
    random_run(150);
    drain();

    // idle/stall phases under mixed settings
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 85 : 33) : 0;
      recv_stall_pct = (ph == 2) ? 85 : ((ph == 3) ? 33 : 0);
      write_reg(CFG_OCTAVE_COUNT, $urandom_range(1, 10));
      write_reg(CFG_PERSISTENCE, $urandom_range(0, 32768));
      random_run(350);
      drain();
    end

    $display("covered %0d checked results over octave counts 0..15 and persistence 0..65535",
             checked);
    $display("four idle/stall mixes plus directed lattice and boundary points");
    if (mismatches == 0 && expected_noise.size() == 0)
      $display("[gradient_noise_3d_octaves] OK");
    else
      $display("[gradient_noise_3d_octaves] ERROR");
    $finish;
  end

  initial begin
    #40ms;
    $display("[gradient_noise_3d_octaves] ERROR");
    $finish;
  end
endmodule

FILE: filelist.f
hw/rtl/gno_pkg.sv
hw/rtl/gno_cell.sv
hw/rtl/gno_div.sv
hw/rtl/gradient_noise_3d_octaves.sv
tb/gradient_noise_3d_octaves_tb.sv
